// File: rtl/core/spl_pkg.sv
// Package for the segment position lookup block.
// Holds widths, command and status codes and the structs shared by the core modules.
// No dependencies.
package spl_pkg;

   // Table geometry and field widths.
   localparam int MAX_SEGMENTS = 1024;
   localparam int SIZE_BITS    = 32;
   localparam int TOTAL_W      = 42;
   localparam int ADDR_W       = $clog2(MAX_SEGMENTS);
   localparam int COUNT_W      = ADDR_W + 1;
   localparam int CMD_W        = 2;
   localparam int STATUS_W     = 2;
   localparam int NUM_W        = 11;
   localparam int OFF_W        = 32;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   // Request commands.
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STS_RANGE = 2'd2;

   // Write port request toward the prefix memory.
   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
      logic [TOTAL_W-1:0] data;
   } ram_wr_type;

   // Read port request toward the prefix memory.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } ram_rd_type;

   // One finished response.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [NUM_W-1:0]    segment_number;
      logic [OFF_W-1:0]    offset_in_segment;
   } result_type;

endpackage

// File: rtl/core/spl_req_if.sv
// Request channel of the segment position lookup block.
// Carries valid, ready and the command payload; depends on spl_pkg.
interface spl_req_if import spl_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [TOTAL_W-1:0] value;

   modport source (output valid, cmd, value, input ready);
   modport sink   (input valid, cmd, value, output ready);
endinterface

// File: rtl/core/spl_rsp_if.sv
// Response channel of the segment position lookup block.
// Carries valid, ready and the result payload; depends on spl_pkg.
interface spl_rsp_if import spl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [NUM_W-1:0]    segment_number;
   logic [OFF_W-1:0]    offset_in_segment;

   modport source (output valid, status, segment_number, offset_in_segment, input ready);
   modport sink   (input valid, status, segment_number, offset_in_segment, output ready);
endinterface

// File: rtl/core/spl_prefix_ram.sv
// Simple dual-port synchronous RAM holding the prefix totals.
// One write port, one read port with registered read data. No dependencies.
module spl_prefix_ram #(
   parameter int  DEPTH = 1024,
   parameter int  WIDTH = 42,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/spl_ctrl.sv
// Sequencer of the segment position lookup block: handles clear and append,
// and runs the lower-bound search over the prefix memory. Depends on spl_pkg
// and the request interface.
module spl_ctrl import spl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   spl_req_if.sink            req_ch,
   output ram_wr_type         ram_wr,
   output ram_rd_type         ram_rd,
   input  logic [TOTAL_W-1:0] ram_rd_data,
   output logic               res_valid,
   input  logic               res_ready,
   output result_type         res
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_RESULT = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [COUNT_W-1:0]  lo_ff, lo_in;
   logic [COUNT_W-1:0]  hi_ff, hi_in;
   logic [ADDR_W-1:0]   mid_ff, mid_in;
   logic [TOTAL_W-1:0]  before_ff, before_in;
   logic [TOTAL_W-1:0]  value_ff, value_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                found_ff, found_in;

   logic [TOTAL_W:0]    sum_wide;
   logic [TOTAL_W-1:0]  sum_sat;
   logic                less;
   logic [COUNT_W-1:0]  step_lo;
   logic [COUNT_W-1:0]  step_hi;
   logic [TOTAL_W-1:0]  step_before;
   logic [ADDR_W-1:0]   step_mid;
   logic [TOTAL_W-1:0]  offset_wide;

   // Saturating running total for an append.
   assign sum_wide = {1'b0, total_ff} + (TOTAL_W + 1)'(req_ch.value[SIZE_BITS-1:0]);
   assign sum_sat  = sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];

   // One search step on the entry read for mid_ff. The last entry probed
   // below the position is the prefix just before the chosen segment.
   assign less        = ram_rd_data < value_ff;
   assign step_lo     = less ? ({1'b0, mid_ff} + COUNT_W'(1)) : lo_ff;
   assign step_hi     = less ? hi_ff : {1'b0, mid_ff};
   assign step_before = less ? ram_rd_data : before_ff;
   assign step_mid    = ADDR_W'(step_lo + ((step_hi - step_lo) >> 1));

   // Sequencing. Appends write in the accept cycle and searches read only
   // later, so a read never overlaps a write to the same entry.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      before_in    = before_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      ram_wr       = '0;
      ram_rd       = '0;
      req_ch.ready = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               status_in = STS_OK;
               found_in  = 1'b0;
               state_in  = ST_RESULT;
               case (req_ch.cmd)
                  CMD_CLEAR: begin
                     count_in = '0;
                     total_in = '0;
                  end
                  CMD_APPEND: begin
                     if (count_ff >= COUNT_W'(MAX_SEGMENTS)) begin
                        status_in = STS_FULL;
                     end else begin
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = count_ff[ADDR_W-1:0];
                        ram_wr.data = sum_sat;
                        count_in    = count_ff + COUNT_W'(1);
                        total_in    = sum_sat;
                     end
                  end
                  CMD_QUERY: begin
                     if (req_ch.value == '0 || req_ch.value > total_ff ||
                         count_ff == '0) begin
                        status_in = STS_RANGE;
                     end else begin
                        value_in    = req_ch.value;
                        lo_in       = '0;
                        hi_in       = count_ff;
                        before_in   = '0;
                        mid_in      = ADDR_W'(count_ff >> 1);
                        ram_rd.en   = 1'b1;
                        ram_rd.addr = ADDR_W'(count_ff >> 1);
                        state_in    = ST_SEARCH;
                     end
                  end
                  default: begin
                     status_in = STS_OK;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            lo_in     = step_lo;
            hi_in     = step_hi;
            before_in = step_before;
            if (step_lo < step_hi) begin
               mid_in      = step_mid;
               ram_rd.en   = 1'b1;
               ram_rd.addr = step_mid;
            end else begin
               found_in = 1'b1;
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         total_ff  <= '0;
         status_ff <= STS_OK;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         total_ff  <= total_in;
         status_ff <= status_in;
         found_ff  <= found_in;
      end
   end

   // Search working registers.
   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      before_ff <= before_in;
      value_ff  <= value_in;
   end

   // Finished result, offered while in the result state.
   assign offset_wide           = value_ff - before_ff;
   assign res_valid             = (state_ff == ST_RESULT);
   assign res.status            = status_ff;
   assign res.segment_number    = found_ff ? NUM_W'(lo_ff + COUNT_W'(1)) : '0;
   assign res.offset_in_segment = found_ff ? offset_wide[OFF_W-1:0] : '0;

endmodule

// File: rtl/core/segment_position_lookup_core.sv
// Segment position lookup: top level with the response output register.
// Depends on spl_pkg, spl_req_if, spl_rsp_if, spl_ctrl and spl_prefix_ram.
//
// Usage:
//  - req_ch carries one request per valid/ready handshake: cmd and value.
//    Clear empties the table, append adds a segment size (low 32 bits) to
//    the running total and stores the new prefix, query maps a 1-based
//    global position to a 1-based segment number and offset.
//  - rsp_ch returns exactly one response per request, in order.
//  - Clear, append, an unused command and an out-of-range query go from the
//    sequencer's result state through the output register to rsp_ch. An
//    in-range query first runs its binary search steps, at most ceil(log2(n + 1))
//    for n stored segments, in a table of up to 1024 entries.
//  - The search does one step per cycle: each step is one read of the
//    prefix memory, whose registered read data is compared in the next cycle.
//  - One request is worked on at a time; req_ch.ready is high while the
//    sequencer is idle, also while a response waits in the output register.
//  - If rsp_ch stalls, the output register holds its response and the next
//    finished response waits in the sequencer until the register frees.
//  - Synchronous reset empties the table (count and total to zero). The
//    prefix memory is not cleared; entries are read only after being written.
module segment_position_lookup_core import spl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   spl_req_if.sink  req_ch,
   spl_rsp_if.source rsp_ch
);

   ram_wr_type         ram_wr;
   ram_rd_type         ram_rd;
   logic [TOTAL_W-1:0] ram_rd_data;
   logic               res_valid;
   logic               res_ready;
   result_type         res;

   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff, rsp_data_in;

   spl_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .ram_wr      (ram_wr),
      .ram_rd      (ram_rd),
      .ram_rd_data (ram_rd_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   spl_prefix_ram #(
      .DEPTH (MAX_SEGMENTS),
      .WIDTH (TOTAL_W)
   ) u_prefix_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (ram_rd.en),
      .rd_addr (ram_rd.addr),
      .rd_data (ram_rd_data)
   );

   // Output register loads when empty or when its response is being taken.
   assign res_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.status            = rsp_data_ff.status;
   assign rsp_ch.segment_number    = rsp_data_ff.segment_number;
   assign rsp_ch.offset_in_segment = rsp_data_ff.offset_in_segment;

endmodule

// File: rtl/core/spl_checker.sv
// Port-level checks for the segment position lookup block, and their binding.
// Depends on spl_pkg; attached to segment_position_lookup_core by bind.
module spl_checker import spl_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [NUM_W-1:0]    rsp_segment_number,
   input logic [OFF_W-1:0]    rsp_offset_in_segment
);

   // No response is offered right after reset.
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response offered right after reset");

   // A stalled response keeps its contents.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_segment_number) && $stable(rsp_offset_in_segment))
      else $error("stalled response changed");

   // One request is worked on at a time, so the request side closes after an accept.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request side stayed open after an accept");

   // Error responses carry no segment and no offset.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STS_OK |->
      rsp_segment_number == '0 && rsp_offset_in_segment == '0)
      else $error("error response with nonzero fields");

   // A found segment always comes with a 1-based offset.
   a_found_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_segment_number != '0 |->
      rsp_status == STS_OK && rsp_offset_in_segment != '0)
      else $error("found segment with zero offset");

endmodule

bind segment_position_lookup_core spl_checker u_spl_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_ch.valid),
   .req_ready             (req_ch.ready),
   .rsp_valid             (rsp_ch.valid),
   .rsp_ready             (rsp_ch.ready),
   .rsp_status            (rsp_ch.status),
   .rsp_segment_number    (rsp_ch.segment_number),
   .rsp_offset_in_segment (rsp_ch.offset_in_segment)
);

// File: tb/segment_position_lookup_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for segment_position_lookup_core: random request and response
// stalls, a prefix-table predictor and an in-order answer check.
// Depends on spl_pkg, spl_req_if, spl_rsp_if and the RTL of the block.
module segment_position_lookup_core_tb;
   import spl_pkg::*;

   // The command code that the block ignores.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Predicts the answer to every accepted request and checks the answers in order.
   class position_lookup_checker;
      logic [TOTAL_W-1:0] prefixes [MAX_SEGMENTS];
      int unsigned        entry_count;
      logic [TOTAL_W-1:0] total;
      result_type         expected_answers [$];
      int                 errors;
      int                 checked;
      int                 located;
      int                 dropped;

      function new();
         entry_count = 0;
         total       = '0;
      endfunction

      function int pending();
         return expected_answers.size();
      endfunction

      task report(input string what);
         errors++;
         if (errors <= 40) $display("%0t ERROR %s", $time, what);
      endtask

      // Updates the table and works out the answer for one request.
      function result_type predict_answer(input logic [CMD_W-1:0] cmd,
                                          input logic [TOTAL_W-1:0] value);
         result_type         ans;
         logic [TOTAL_W:0]   sum;
         logic [TOTAL_W-1:0] below;
         int unsigned        lo;
         int unsigned        hi;
         int unsigned        mid;
         ans = '0;
         case (cmd)
            CMD_CLEAR: begin
               entry_count = 0;
               total       = '0;
            end
            CMD_APPEND: begin
               if (entry_count >= MAX_SEGMENTS) begin
                  ans.status = STS_FULL;
               end else begin
                  sum = {1'b0, total} + value[SIZE_BITS-1:0];
                  if (sum > TOTAL_MAX) sum = TOTAL_MAX;
                  total = sum[TOTAL_W-1:0];
                  prefixes[entry_count] = total;
                  entry_count++;
               end
            end
            CMD_QUERY: begin
               if (value == '0 || value > total || entry_count == 0) begin
                  ans.status = STS_RANGE;
               end else begin
                  // Lower bound: first stored prefix that reaches the position.
                  lo = 0;
                  hi = entry_count;
                  while (lo < hi) begin
                     mid = lo + (hi - lo) / 2;
                     if (prefixes[mid] < value) lo = mid + 1;
                     else hi = mid;
                  end
                  if (lo >= entry_count) begin
                     ans.status = STS_RANGE;
                  end else begin
                     below                 = (lo > 0) ? prefixes[lo-1] : '0;
                     ans.status            = STS_OK;
                     ans.segment_number    = NUM_W'(lo + 1);
                     ans.offset_in_segment = OFF_W'(value - below);
                  end
               end
            end
            default: ;
         endcase
         return ans;
      endfunction

      function void note_request(input logic [CMD_W-1:0] cmd,
                                 input logic [TOTAL_W-1:0] value);
         result_type ans;
         ans = predict_answer(cmd, value);
         if (ans.status == STS_FULL) dropped++;
         if (cmd == CMD_QUERY && ans.status == STS_OK) located++;
         expected_answers.insert(expected_answers.size(), ans);
      endfunction

      task check_answer(input logic [STATUS_W-1:0] status,
                        input logic [NUM_W-1:0]    number,
                        input logic [OFF_W-1:0]    offset);
         result_type want;
         if (expected_answers.size() == 0) begin
            report($sformatf("answer with no request outstanding (status %0d)", status));
            return;
         end
         want = expected_answers.pop_front();
         checked++;
         if (status !== want.status)
            report($sformatf("answer %0d: status %0d, expected %0d",
                             checked, status, want.status));
         if (number !== want.segment_number)
            report($sformatf("answer %0d: segment %0d, expected %0d",
                             checked, number, want.segment_number));
         if (offset !== want.offset_in_segment)
            report($sformatf("answer %0d: offset %0d, expected %0d",
                             checked, offset, want.offset_in_segment));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   sent;
   int   send_quiet;
   int   take_quiet;

   position_lookup_checker chk;

   spl_req_if req_bus ();
   spl_rsp_if rsp_bus ();

   segment_position_lookup_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always #5 clock = ~clock;

   // Wait before the next handshake: drawn at random, with runs of no waiting.
   function automatic int draw_gap(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) quiet = $urandom_range(10, 40);
      return $urandom_range(0, 12);
   endfunction

   function automatic logic [TOTAL_W-1:0] rand_total();
      return TOTAL_W'({$urandom, $urandom});
   endfunction

   // Segment size; the upper bits of the value are sometimes set, they must be ignored.
   function automatic logic [TOTAL_W-1:0] pick_size(input int flavor);
      logic [TOTAL_W-1:0]   upper;
      logic [SIZE_BITS-1:0] low;
      upper = ($urandom_range(0, 3) == 0) ? rand_total() : '0;
      case (flavor)
         0:       low = $urandom_range(1, 16);
         1:       low = ($urandom_range(0, 1) == 0) ? '0 : SIZE_BITS'($urandom_range(1, 4));
         2:       low = $urandom;
         default: begin
            case ($urandom_range(0, 3))
               0:       low = '0;
               1:       low = '1;
               2:       low = $urandom;
               default: low = $urandom_range(1, 100);
            endcase
         end
      endcase
      return {upper[TOTAL_W-1:SIZE_BITS], low};
   endfunction

   // Position for a query: mostly inside the table, plus edges and noise.
   function automatic logic [TOTAL_W-1:0] pick_position();
      int unsigned idx;
      case ($urandom_range(0, 15))
         0: return '0;
         1: return chk.total;
         2: return chk.total + 1'b1;
         3: return rand_total();
         4, 5: begin
            if (chk.entry_count == 0) return rand_total();
            idx = $urandom_range(0, chk.entry_count - 1);
            return chk.prefixes[idx] + TOTAL_W'($urandom_range(0, 1));
         end
         default: begin
            if (chk.total == '0) return rand_total();
            return (rand_total() % chk.total) + 1'b1;
         end
      endcase
   endfunction

   // Presents one request after a random gap and returns once it is accepted.
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [TOTAL_W-1:0] value);
      int gap;
      gap = draw_gap(send_quiet);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd   <= cmd;
      req_bus.value <= value;
      do @(posedge clock); while (!req_bus.ready);
      chk.note_request(cmd, value);
      sent++;
   endtask

   // Holds the request side idle until every answer has come back.
   task automatic hold_until_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (chk.pending() != 0) @(posedge clock);
   endtask

   // Mostly a clear first, then a run of appends, then mostly queries with some appends and noise mixed in.
   task automatic run_segment_burst();
      int flavor;
      int n_app;
      int n_query;
      flavor = $urandom_range(0, 3);
      if ($urandom_range(0, 4) != 0) send_request(CMD_CLEAR, rand_total());
      n_app = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 40);
      repeat (n_app) send_request(CMD_APPEND, pick_size(flavor));
      n_query = $urandom_range(4, 20);
      repeat (n_query) begin
         case ($urandom_range(0, 11))
            0:       send_request(CMD_APPEND, pick_size(flavor));
            1:       send_request(CMD_W'($urandom_range(0, 3)), rand_total());
            default: send_request(CMD_QUERY, pick_position());
         endcase
      end
   endtask

   // Response side: random stalls, then one checked answer per handshake.
   initial begin : answer_taker
      int stall;
      wait (!reset);
      forever begin
         stall = draw_gap(take_quiet);
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         chk.check_answer(rsp_bus.status, rsp_bus.segment_number,
                          rsp_bus.offset_in_segment);
      end
   end

   // Main sequence: reset, directed cases, random bursts with one full-table phase.
   initial begin
      chk           = new();
      req_bus.valid = 1'b0;
      req_bus.cmd   = CMD_CLEAR;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table and the ignored command.
      send_request(CMD_QUERY, 42'd1);
      send_request(CMD_QUERY, '0);
      send_request(CMD_QUERY, TOTAL_MAX);
      send_request(CMD_UNUSED, TOTAL_MAX);
      // Size 5 with upper bits set, a zero-size segment, the largest size, size 1.
      send_request(CMD_APPEND, 42'h3FF_0000_0005);
      send_request(CMD_APPEND, '0);
      send_request(CMD_APPEND, 42'h0_FFFF_FFFF);
      send_request(CMD_APPEND, 42'd1);
      send_request(CMD_QUERY, '0);
      send_request(CMD_QUERY, 42'd1);
      send_request(CMD_QUERY, 42'd5);
      send_request(CMD_QUERY, 42'd6);
      send_request(CMD_QUERY, 42'h1_0000_0004);
      send_request(CMD_QUERY, 42'h1_0000_0005);
      send_request(CMD_QUERY, 42'h1_0000_0006);
      send_request(CMD_QUERY, TOTAL_MAX);
      send_request(CMD_UNUSED, '0);
      // Clear, then a fresh table.
      send_request(CMD_CLEAR, TOTAL_MAX);
      send_request(CMD_QUERY, 42'd1);
      send_request(CMD_APPEND, 42'd3);
      send_request(CMD_QUERY, 42'd3);
      send_request(CMD_QUERY, 42'd4);
      hold_until_drained();

      while (sent < 300) run_segment_burst();

      // Fill the table, try to append past the end, then search the full table.
      send_request(CMD_CLEAR, '0);
      repeat (MAX_SEGMENTS) send_request(CMD_APPEND, pick_size($urandom_range(0, 3)));
      repeat (4) send_request(CMD_APPEND, rand_total());
      repeat (60) send_request(CMD_QUERY, pick_position());
      hold_until_drained();

      while (sent < 1500) begin
         run_segment_burst();
         if ($urandom_range(0, 7) == 0) hold_until_drained();
      end
      hold_until_drained();
      repeat (30) @(posedge clock);

      $display("Run sent %0d requests and checked %0d answers;", sent, chk.checked);
      $display("%0d queries found a segment and %0d appends met a full table.",
               chk.located, chk.dropped);
      if (chk.errors == 0) begin
         $display("segment_position_lookup_core_tb passed");
      end else begin
         $display("segment_position_lookup_core_tb failed");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin : watchdog
      #10_000_000;
      $display("Timeout with %0d answers outstanding.", chk.pending());
      $display("segment_position_lookup_core_tb failed");
      $finish;
   end

endmodule
